### hw/rtl/bml_pkg.sv
package bml_pkg;

    // Azimuth table
    localparam int NUM_AZ   = 512;
    localparam int AZ_IDX_W = $clog2(NUM_AZ);

    // Field widths
    localparam int LEN_W  = 12;
    localparam int BW_W   = 9;
    localparam int HGT_W  = 15;
    localparam int ELEV_W = 15;
    localparam int BIN_W  = 14;
    localparam int ANG_W  = 15;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_W  = 2'd1;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0] LEN_RST = 12'd250;
    localparam logic [BW_W-1:0]  BW_RST  = 9'd100;

    // Angles in 0.005 degree units
    localparam logic signed [17:0] ANG_360 = 18'sd72000;
    localparam logic [16:0]        ANG_180 = 17'd36000;
    localparam logic [16:0]        ANG_90  = 17'd18000;

    // Fixed-point constants
    localparam logic [22:0] EARTH_A   = 23'd7708910;
    localparam logic [32:0] RAD_Q46   = 33'd6140831382;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [30:0] HORN_INIT = 31'd27;
    localparam int          HORN_N    = 5;
    localparam logic [30:0] HORN_COEF [HORN_N] = '{
        31'd2959, 31'd213044, 31'd8947849, 31'd178956971, 31'h4000_0000
    };

    // Pipeline depths
    localparam int SQ_STEPS = 32;
    localparam int DIV_BITS = BIN_W;
    localparam int LANE_LAT = 10 + SQ_STEPS + 2 + DIV_BITS;
    localparam int PIPE_LAT = 2 + LANE_LAT + 1;
    localparam int NUM_LANES = 4;

    typedef struct packed {
        logic [ANG_W-1:0] a;
        logic             neg;
    } t_fold;

    typedef struct packed {
        logic [ANG_W-1:0] a;
        logic             neg;
        logic [HGT_W-1:0] height;
    } t_lane_in;

    // Fold an angle to [0, 90] degrees with a sign flag
    function automatic t_fold fold_angle(input logic signed [17:0] ang);
        logic signed [17:0] m;
        logic [16:0]        a;
        t_fold              f;
        m = ang;
        if (m < 0) begin
            m = m + ANG_360;
        end
        a     = 17'(m);
        f.neg = 1'b0;
        if (a >= ANG_180) begin
            a     = a - ANG_180;
            f.neg = 1'b1;
        end
        if (a > ANG_90) begin
            a = ANG_180 - a;
        end
        f.a = ANG_W'(a);
        return f;
    endfunction

endpackage

### hw/rtl/bml_lane.sv
module bml_lane import bml_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_lane_in         i_in,
    input  logic [LEN_W-1:0] i_len,
    output logic [BIN_W-1:0] o_bin
);

    // Sine and projection stages
    logic [30:0]      r_x   [0:6];
    logic [31:0]      r_x2  [1:5];
    logic [30:0]      r_t   [0:HORN_N-1];
    logic             r_neg [0:8];
    logic [HGT_W-1:0] r_h   [0:7];
    logic [30:0]      r_s;
    logic [30:0]      r_p;
    logic [63:0]      r_ha;

    // Square root stages
    logic [63:0] r_sv   [0:SQ_STEPS];
    logic [63:0] r_sres [0:SQ_STEPS];
    logic [30:0] r_sp   [0:SQ_STEPS];
    logic        r_sneg [0:SQ_STEPS];
    logic [63:0] n_sv   [0:SQ_STEPS-1];
    logic [63:0] n_sres [0:SQ_STEPS-1];

    // Divider stages
    logic [33:0]      r_n;
    logic [33:0]      r_rem [0:DIV_BITS];
    logic [BIN_W-1:0] r_q   [0:DIV_BITS];
    logic             r_sat [0:DIV_BITS];
    logic [33:0]      n_rem [0:DIV_BITS-1];
    logic [BIN_W-1:0] n_q   [0:DIV_BITS-1];

    logic [LEN_W-1:0] len_eff;
    logic [19:0]      div_d;
    logic [31:0]      root;

    // Zero bin length counts as one metre
    assign len_eff = (i_len == '0) ? LEN_W'(1) : i_len;
    assign div_d   = {len_eff, 8'd0};
    assign root    = r_sres[SQ_STEPS][31:0];

    // One restoring square-root step per stage
    always_comb begin
        logic [63:0] bitk;
        logic [63:0] sum;
        for (int k = 0; k < SQ_STEPS; k++) begin
            bitk = 64'(1) << (62 - 2 * k);
            sum  = r_sres[k] + bitk;
            if (r_sv[k] >= sum) begin
                n_sv[k]   = r_sv[k] - sum;
                n_sres[k] = (r_sres[k] >> 1) + bitk;
            end else begin
                n_sv[k]   = r_sv[k];
                n_sres[k] = r_sres[k] >> 1;
            end
        end
    end

    // One quotient bit per stage
    always_comb begin
        logic [33:0] sh;
        for (int i = 0; i < DIV_BITS; i++) begin
            sh       = 34'(div_d) << (DIV_BITS - 1 - i);
            n_rem[i] = r_rem[i];
            n_q[i]   = r_q[i];
            if (r_rem[i] >= sh) begin
                n_rem[i]                 = r_rem[i] - sh;
                n_q[i][DIV_BITS - 1 - i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [47:0] px;
        logic [63:0] pm;
        logic [54:0] pa;
        logic [32:0] rr;
        if (i_en) begin
            // Angle to radians in Q30
            px       = 48'(i_in.a) * 48'(RAD_Q46);
            r_x[0]   <= 31'(px >> 16);
            r_neg[0] <= i_in.neg;
            r_h[0]   <= i_in.height;

            // Square of the angle
            pm       = 64'(r_x[0]) * 64'(r_x[0]);
            r_x2[1]  <= 32'(pm >> 30);

            // Carry angle, sign and height
            for (int k = 1; k <= 6; k++) begin
                r_x[k] <= r_x[k-1];
            end
            for (int k = 1; k <= 8; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            for (int k = 1; k <= 7; k++) begin
                r_h[k] <= r_h[k-1];
            end

            // Horner steps of the odd sine series
            for (int j = 0; j < HORN_N; j++) begin
                pm     = 64'(r_x2[1+j]) * 64'((j == 0) ? HORN_INIT : r_t[(j == 0) ? 0 : j-1]);
                r_t[j] <= HORN_COEF[j] - 31'(pm >> 30);
                if (j < HORN_N - 1) begin
                    r_x2[2+j] <= r_x2[1+j];
                end
            end

            // Final sine product, clamped to one
            pm  = 64'(r_x[6]) * 64'(r_t[HORN_N-1]);
            r_s <= (32'(pm >> 30) > 32'(ONE_Q30)) ? ONE_Q30 : 31'(pm >> 30);

            // Earth radius times sine in Q8, and the height term
            pa   = 55'(EARTH_A) * 55'(r_s) + 55'(1 << 21);
            r_p  <= 31'(pa >> 22);
            r_ha <= (64'(r_h[7]) * 64'({EARTH_A, 1'b0})) << 16;

            // Radicand
            r_sv[0]   <= r_ha + 64'(r_p) * 64'(r_p);
            r_sres[0] <= '0;
            r_sp[0]   <= r_p;
            r_sneg[0] <= r_neg[8];

            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sv[k+1]   <= n_sv[k];
                r_sres[k+1] <= n_sres[k];
                r_sp[k+1]   <= r_sp[k];
                r_sneg[k+1] <= r_sneg[k];
            end

            // Slant range plus half a bin
            rr  = r_sneg[SQ_STEPS] ? 33'(root) + 33'(r_sp[SQ_STEPS])
                                   : 33'(root) - 33'(r_sp[SQ_STEPS]);
            r_n <= 34'(rr) + (34'(len_eff) << 7);

            // Saturate where the quotient would not fit
            r_rem[0] <= r_n;
            r_q[0]   <= '0;
            r_sat[0] <= r_n >= (34'(div_d) << DIV_BITS);

            for (int i = 0; i < DIV_BITS; i++) begin
                r_rem[i+1] <= n_rem[i];
                r_q[i+1]   <= n_q[i];
                r_sat[i+1] <= r_sat[i];
            end
        end
    end

    assign o_bin = r_sat[DIV_BITS] ? '1 : r_q[DIV_BITS];

endmodule

### hw/rtl/beam_melting_layer_bins.sv
// Channel   Direction  Handshake                    Payload
// input     in         i_valid / o_stall            i_kind, i_azimuth, i_elevation_centideg,
//                                                   i_top_height_m, i_bottom_height_m
// result    out        o_valid / i_stall            o_start_bin, o_center_bottom_bin,
//                                                   o_center_top_bin, o_end_bin
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item per cycle unless a stalled result holds the pipeline; a compute item's result comes
// from the 32-step square root and 14-step divider in each of the four range lanes.
// Load items write the height memory on transfer and give no result.
// Synchronous active-low reset clears valid bits, resets configuration; memory is not cleared.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module beam_melting_layer_bins import bml_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_kind,
    input  logic [8:0]               i_azimuth,
    input  logic signed [ELEV_W-1:0] i_elevation_centideg,
    input  logic [HGT_W-1:0]         i_top_height_m,
    input  logic [HGT_W-1:0]         i_bottom_height_m,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [BIN_W-1:0]         o_start_bin,
    output logic [BIN_W-1:0]         o_center_bottom_bin,
    output logic [BIN_W-1:0]         o_center_top_bin,
    output logic [BIN_W-1:0]         o_end_bin,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [LEN_W-1:0]         i_cfg_data
);

    logic [LEN_W-1:0]         r_bin_len;
    logic [BW_W-1:0]          r_beam_w;
    logic [PIPE_LAT-1:0]      r_vld;
    logic [2*HGT_W-1:0]       r_mem [NUM_AZ];
    logic [2*HGT_W-1:0]       r_rd;
    logic                     r_inr;
    logic signed [ELEV_W-1:0] r_elev;
    t_lane_in                 r_lane_in [NUM_LANES];
    logic [BIN_W-1:0]         lane_bin [NUM_LANES];
    logic [BIN_W-1:0]         r_out [NUM_LANES];

    logic                     en;
    logic                     accept;
    logic                     az_ok;
    logic [AZ_IDX_W-1:0]      az_idx;
    logic signed [17:0]       e2;
    logic signed [17:0]       bw;
    logic [HGT_W-1:0]         top_h;
    logic [HGT_W-1:0]         bot_h;

    assign en          = !(r_vld[PIPE_LAT-1] && i_stall);
    assign o_stall     = !en;
    assign accept      = i_valid && en;
    assign o_cfg_ready = 1'b1;
    assign az_ok       = 32'(i_azimuth) < NUM_AZ;
    assign az_idx      = AZ_IDX_W'(i_azimuth);

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_len <= LEN_RST;
            r_beam_w  <= BW_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_BIN_LEN) begin
                r_bin_len <= i_cfg_data;
            end else if (i_cfg_index == CFG_BEAM_W) begin
                r_beam_w <= i_cfg_data[BW_W-1:0];
            end
        end
    end

    // Valid bits advance with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], accept && i_kind};
        end
    end

    // Height memory: write on load transfer, registered read
    always_ff @(posedge i_clk) begin
        if (accept && !i_kind && az_ok) begin
            r_mem[az_idx] <= {i_top_height_m, i_bottom_height_m};
        end
        if (en) begin
            r_rd   <= r_mem[az_idx];
            r_inr  <= az_ok;
            r_elev <= i_elevation_centideg;
        end
    end

    // Four lane inputs from three folded beam angles
    assign e2    = {{2{r_elev[ELEV_W-1]}}, r_elev, 1'b0};
    assign bw    = {9'd0, r_beam_w};
    assign top_h = r_inr ? r_rd[2*HGT_W-1:HGT_W] : '0;
    assign bot_h = r_inr ? r_rd[HGT_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        t_fold f0;
        t_fold f1;
        t_fold f3;
        if (en) begin
            f0 = fold_angle(e2 + bw);
            f1 = fold_angle(e2);
            f3 = fold_angle(e2 - bw);
            r_lane_in[0] <= '{a: f0.a, neg: f0.neg, height: bot_h};
            r_lane_in[1] <= '{a: f1.a, neg: f1.neg, height: bot_h};
            r_lane_in[2] <= '{a: f1.a, neg: f1.neg, height: top_h};
            r_lane_in[3] <= '{a: f3.a, neg: f3.neg, height: top_h};
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bml_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_in  (r_lane_in[g]),
            .i_len (r_bin_len),
            .o_bin (lane_bin[g])
        );
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_out[k] <= lane_bin[k];
            end
        end
    end

    assign o_valid             = r_vld[PIPE_LAT-1];
    assign o_start_bin         = r_out[0];
    assign o_center_bottom_bin = r_out[1];
    assign o_center_top_bin    = r_out[2];
    assign o_end_bin           = r_out[3];

    // Checks
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_kind |=> !r_vld[0])
        else $error("load transfer entered the result pipeline");

    a_compute_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_kind |=> r_vld[0])
        else $error("compute transfer lost at pipeline entry");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

### tb/beam_melting_layer_bins_tb.sv
`timescale 1ns / 1ps

module beam_melting_layer_bins_tb;
    import bml_pkg::*;

    typedef struct packed {
        logic [BIN_W-1:0] start_bin;
        logic [BIN_W-1:0] center_bottom_bin;
        logic [BIN_W-1:0] center_top_bin;
        logic [BIN_W-1:0] end_bin;
    } t_bins;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;
    localparam longint CYCLE_LIMIT = 400000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_kind = 1'b0;
    logic [8:0]               i_azimuth = '0;
    logic signed [ELEV_W-1:0] i_elevation_centideg = '0;
    logic [HGT_W-1:0]         i_top_height_m = '0;
    logic [HGT_W-1:0]         i_bottom_height_m = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [BIN_W-1:0]         o_start_bin;
    logic [BIN_W-1:0]         o_center_bottom_bin;
    logic [BIN_W-1:0]         o_center_top_bin;
    logic [BIN_W-1:0]         o_end_bin;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [LEN_W-1:0]         i_cfg_data = '0;

    int     mismatch_count = 0;
    longint cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     loaded [NUM_AZ];

    beam_melting_layer_bins uut (.*);

    always #6 i_clk = ~i_clk;

    // Print one line per mismatch and count it
    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    // Predicts layer bins and holds the bins still owed by the block
    class bins_scoreboard;
        logic [LEN_W-1:0] bin_len;
        logic [BW_W-1:0]  beam_w;
        logic [HGT_W-1:0] tops [NUM_AZ];
        logic [HGT_W-1:0] bottoms [NUM_AZ];
        t_bins            owed [$];

        function new();
            bin_len = LEN_RST;
            beam_w  = BW_RST;
            foreach (tops[i]) begin
                tops[i] = '0;
                bottoms[i] = '0;
            end
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] d);
            if (idx == CFG_BIN_LEN) begin
                bin_len = d;
            end else if (idx == CFG_BEAM_W) begin
                beam_w = d[BW_W-1:0];
            end
        endfunction

        // |sin| in Q30 of an angle in 0.005 degree units within [0, 90] degrees
        function longint unsigned sine_q30(input longint unsigned a);
            longint unsigned x, x2, t;
            x  = (a * 64'd6140831382) >> 16;
            x2 = (x * x) >> 30;
            t  = 27;
            t  = 2959 - ((x2 * t) >> 30);
            t  = 213044 - ((x2 * t) >> 30);
            t  = 8947849 - ((x2 * t) >> 30);
            t  = 178956971 - ((x2 * t) >> 30);
            t  = (64'd1 << 30) - ((x2 * t) >> 30);
            t  = (x * t) >> 30;
            return (t > (64'd1 << 30)) ? (64'd1 << 30) : t;
        endfunction

        function longint unsigned int_sqrt(input longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function logic [BIN_W-1:0] slant_bin(input int ang, input longint unsigned h);
            int m;
            longint unsigned a, s, p, root, r, len, bin;
            bit neg;
            neg = 0;
            m = ang % 72000;
            if (m < 0) m += 72000;
            a = m;
            if (a >= 36000) begin
                a -= 36000;
                neg = 1;
            end
            if (a > 18000) a = 36000 - a;
            s = sine_q30(a);
            p = (64'd7708910 * s + (64'd1 << 21)) >> 22;
            root = int_sqrt(((2 * h * 64'd7708910) << 16) + p * p);
            r = neg ? root + p : root - p;
            len = (bin_len == 0) ? 1 : bin_len;
            bin = (r + (len << 7)) / (len << 8);
            return (bin > 16383) ? 14'd16383 : bin[BIN_W-1:0];
        endfunction

        function void note_input(input logic kind, input logic [8:0] az,
                                 input logic signed [ELEV_W-1:0] elev,
                                 input logic [HGT_W-1:0] top, input logic [HGT_W-1:0] bot);
            t_bins b;
            int e2, bw;
            longint unsigned ht, hb;
            if (kind == KIND_LOAD) begin
                if (az < NUM_AZ) begin
                    tops[az] = top;
                    bottoms[az] = bot;
                end
                return;
            end
            ht = (az < NUM_AZ) ? tops[az] : 0;
            hb = (az < NUM_AZ) ? bottoms[az] : 0;
            e2 = 2 * int'(elev);
            bw = beam_w;
            b.start_bin         = slant_bin(e2 + bw, hb);
            b.center_bottom_bin = slant_bin(e2, hb);
            b.center_top_bin    = slant_bin(e2, ht);
            b.end_bin           = slant_bin(e2 - bw, ht);
            owed.push_back(b);
        endfunction

        task check_result(input t_bins got);
            t_bins want;
            if (owed.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            want = owed.pop_front();
            if (got.start_bin != want.start_bin)
                report($sformatf("start_bin %0d want %0d", got.start_bin, want.start_bin));
            if (got.center_bottom_bin != want.center_bottom_bin)
                report($sformatf("center_bottom_bin %0d want %0d",
                                 got.center_bottom_bin, want.center_bottom_bin));
            if (got.center_top_bin != want.center_top_bin)
                report($sformatf("center_top_bin %0d want %0d",
                                 got.center_top_bin, want.center_top_bin));
            if (got.end_bin != want.end_bin)
                report($sformatf("end_bin %0d want %0d", got.end_bin, want.end_bin));
        endtask
    endclass

    bins_scoreboard bins_sb = new();

    // Sample transfers at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                bins_sb.note_input(i_kind, i_azimuth, i_elevation_centideg,
                                   i_top_height_m, i_bottom_height_m);
            if (o_valid && !i_stall)
                bins_sb.check_result({o_start_bin, o_center_bottom_bin,
                                      o_center_top_bin, o_end_bin});
        end
    end

    // Randomise receiver stall at the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [8:0] az,
                             input logic signed [ELEV_W-1:0] elev,
                             input logic [HGT_W-1:0] top, input logic [HGT_W-1:0] bot);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_azimuth <= az;
        i_elevation_centideg <= elev;
        i_top_height_m <= top;
        i_bottom_height_m <= bot;
        // hold until transferred
        do @(posedge i_clk); while (o_stall);
        if (kind == KIND_LOAD && az < NUM_AZ) loaded[az] = 1;
        @(negedge i_clk);
    endtask

    task automatic load(input logic [8:0] az, input logic [HGT_W-1:0] top,
                        input logic [HGT_W-1:0] bot);
        send_item(KIND_LOAD, az, '0, top, bot);
    endtask

    // Compute only on a loaded azimuth or one beyond the table
    task automatic compute(input logic [8:0] az, input logic signed [ELEV_W-1:0] elev);
        send_item(KIND_COMPUTE, az, elev, HGT_W'($urandom), HGT_W'($urandom));
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (bins_sb.owed.size() != 0) @(negedge i_clk);
        while (waited < PIPE_LAT + 10) begin
            @(negedge i_clk);
            waited++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        bins_sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [ELEV_W-1:0] rand_elev();
        int r;
        r = $urandom_range(99);
        if (r < 10) return ELEV_W'($urandom);
        if (r < 40) return ELEV_W'(int'($urandom_range(200)) - 200);
        if (r < 85) return ELEV_W'($urandom_range(2000));
        return ELEV_W'($urandom_range(9000));
    endfunction

    task automatic random_phase(input int n);
        logic [8:0] az;
        repeat (n) begin
            if ($urandom_range(99) < 30) begin
                // loads beyond the first 64 azimuths stay rare
                az = ($urandom_range(19) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(63));
                load(az, HGT_W'($urandom_range(20000)), HGT_W'($urandom_range(20000)));
            end else begin
                az = 9'($urandom_range(63));
                if (!loaded[az]) load(az, HGT_W'($urandom), HGT_W'($urandom));
                compute(az, rand_elev());
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: height extremes, elevation extremes, wrap, reset registers
        load(0, 0, 0);
        load(1, 20000, 20000);
        load(2, 15'h7FFF, 15'h7FFF);
        load(3, 5000, 1000);
        load(511, 12345, 6789);
        compute(0, 0);
        compute(1, -200);
        compute(1, 9000);
        compute(2, 0);
        compute(2, 15'sh3FFF);
        compute(2, 15'sh4000);
        compute(3, 1);
        compute(3, 45);
        compute(511, 4500);
        compute(1, -16000);
        compute(3, 18000 - 36000 + 1);
        drain();

        // Extremes of both registers, zero bin length included
        write_reg(CFG_BIN_LEN, 1);
        write_reg(CFG_BEAM_W, 500);
        compute(1, 0);
        compute(2, 9000);
        compute(3, -200);
        drain();
        write_reg(CFG_BIN_LEN, 0);
        write_reg(CFG_BEAM_W, 1);
        compute(3, 50);
        compute(0, 9000);
        drain();
        write_reg(CFG_BIN_LEN, 4095);
        write_reg(CFG_BEAM_W, 9'h1FF);
        write_reg(2'd3, 12'hABC);
        compute(2, 1);
        compute(1, -200);
        drain();

        send_idle_pct = 30;
        recv_stall_pct = 59;
        write_reg(CFG_BIN_LEN, 12'($urandom_range(1, 4095)));
        write_reg(CFG_BEAM_W, 9'($urandom_range(1, 500)));
        random_phase(130);
        drain();

        send_idle_pct = 59;
        recv_stall_pct = 30;
        write_reg(CFG_BIN_LEN, 12'($urandom_range(1, 300)));
        write_reg(CFG_BEAM_W, 9'($urandom_range(1, 500)));
        random_phase(130);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(CFG_BIN_LEN, LEN_RST);
        write_reg(CFG_BEAM_W, BW_RST);
        random_phase(140);
        drain();

        if (mismatch_count == 0 && bins_sb.owed.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
